// ----- hw/rtl/pinhole_camera_ray_direction_defines.svh -----
// assertion helpers for the ray direction block
`ifndef PINHOLE_CAMERA_RAY_DIRECTION_DEFINES_SVH
`define PINHOLE_CAMERA_RAY_DIRECTION_DEFINES_SVH

// clocked check, quiet while reset is high
`define PCRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds across reset
`define PCRD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/pcrd_pkg.sv -----
package pcrd_pkg;

   // normalized magnitude, sum of squares, root, remainder, fraction, quotient and numerator widths
   localparam int MAG_W  = 30;
   localparam int SUM_W  = 62;
   localparam int ROOT_W = 31;
   localparam int REM_W  = 33;
   localparam int FRAC_W = 14;
   localparam int Q_W    = 15;
   localparam int NUM_W  = MAG_W + FRAC_W + 1;
   localparam int DREM_W = ROOT_W + 1;

   // register indexes
   localparam logic [2:0] CSR_AXIS_RIGHT   = 3'd0;
   localparam logic [2:0] CSR_AXIS_UP      = 3'd1;
   localparam logic [2:0] CSR_AXIS_BACK    = 3'd2;
   localparam logic [2:0] CSR_FOCAL        = 3'd3;
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd5;

   typedef logic [MAG_W-1:0] mag_type;

   // normalized direction word traveling down the back half of the pipe
   typedef struct packed {
      mag_type [2:0] mag;
      logic [2:0]    neg;
      logic          zero;
   } vec_type;

endpackage

// ----- hw/rtl/pcrd_vec.sv -----
module pcrd_vec #(
   parameter int PIXEL_BITS = 12,
   parameter int MW = 35
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [PIXEL_BITS-1:0] pixel_x,
   input  logic [PIXEL_BITS-1:0] pixel_y,
   input  logic [47:0]           axis_right,
   input  logic [47:0]           axis_up,
   input  logic [47:0]           axis_back,
   input  logic [15:0]           focal_distance,
   input  logic [12:0]           frame_width,
   input  logic [12:0]           frame_height,
   output logic                  out_valid,
   output logic [MW-1:0]         out_mag [3],
   output logic [2:0]            out_neg
);

   localparam int AW = ((PIXEL_BITS > 12) ? PIXEL_BITS : 12) + 1;
   localparam int PW = AW + 16;
   localparam int BW = 33;

   logic                 valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic signed [AW-1:0] a_in, b_in, a_ff, b_ff;
   logic signed [PW-1:0] pr_in [3], pu_in [3], pr_ff [3], pu_ff [3];
   logic signed [BW-1:0] pb_in [3], pb_ff [3];
   logic signed [MW-1:0] v_in [3], v_ff [3];
   logic [MW-1:0]        mag_in [3], mag_ff [3];
   logic [2:0]           neg_in, neg_ff;

   // pixel offsets from the image center
   assign a_in = $signed(AW'(pixel_x)) - $signed(AW'(frame_width[12:1]));
   assign b_in = $signed(AW'(frame_height[12:1])) - $signed(AW'(pixel_y));

   // products per axis component
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr_in[i] = a_ff * $signed(axis_right[16*i +: 16]);
         pu_in[i] = b_ff * $signed(axis_up[16*i +: 16]);
         pb_in[i] = $signed({1'b0, focal_distance}) * $signed(axis_back[16*i +: 16]);
      end
   end

   // combine into Q.18 direction, then split sign and magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_in[i] = ((MW'(pr_ff[i]) + MW'(pu_ff[i])) <<< 4) - MW'(pb_ff[i]);
         neg_in[i] = v_ff[i][MW-1];
         mag_in[i] = neg_in[i] ? MW'(-v_ff[i]) : MW'(v_ff[i]);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         pr_ff  <= pr_in;
         pu_ff  <= pu_in;
         pb_ff  <= pb_in;
         v_ff   <= v_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign out_valid = valid4_ff;
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule

// ----- hw/rtl/pcrd_norm.sv -----
module pcrd_norm #(
   parameter int MW = 35
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [MW-1:0]             in_mag [3],
   input  logic [2:0]                in_neg,
   output logic                      out_valid,
   output pcrd_pkg::vec_type         out_vec,
   output logic [pcrd_pkg::SUM_W-1:0] out_sum
);

   localparam int LW = $clog2(MW);
   localparam int TOP = pcrd_pkg::MAG_W - 1;
   localparam int SQ_W = 2 * pcrd_pkg::MAG_W;

   logic          va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic [MW-1:0] m_in, m_ff;
   logic [MW-1:0] mag_a_ff [3], mag_b_ff [3];
   logic [2:0]    neg_a_ff, neg_b_ff;
   logic [LW-1:0] lead_in, amt_in, amt_ff;
   logic          left_in, left_ff, zero_in, zero_ff;
   pcrd_pkg::vec_type vec_c_in, vec_c_ff, vec_d_ff, vec_e_ff;
   logic [SQ_W-1:0] sq_in [3], sq_ff [3];
   logic [pcrd_pkg::SUM_W-1:0] sum_in, sum_ff;

   // largest magnitude
   always_comb begin
      m_in = in_mag[0];
      if (in_mag[1] > m_in) m_in = in_mag[1];
      if (in_mag[2] > m_in) m_in = in_mag[2];
   end

   // leading one of the largest magnitude sets one common shift
   always_comb begin
      lead_in = '0;
      for (int k = 0; k < MW; k++) begin
         if (m_ff[k]) lead_in = LW'(k);
      end
      zero_in = (m_ff == '0);
      left_in = (lead_in < LW'(TOP));
      amt_in  = left_in ? (LW'(TOP) - lead_in) : (lead_in - LW'(TOP));
   end

   // apply the shift
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec_c_in.mag[i] = left_ff ? pcrd_pkg::MAG_W'(mag_b_ff[i] << amt_ff)
                                   : pcrd_pkg::MAG_W'(mag_b_ff[i] >> amt_ff);
      end
      vec_c_in.neg  = neg_b_ff;
      vec_c_in.zero = zero_ff;
   end

   // squares and their sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(vec_c_ff.mag[i]) * SQ_W'(vec_c_ff.mag[i]);
      end
      sum_in = pcrd_pkg::SUM_W'(sq_ff[0]) + pcrd_pkg::SUM_W'(sq_ff[1])
             + pcrd_pkg::SUM_W'(sq_ff[2]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      if (en) begin
         m_ff     <= m_in;
         mag_a_ff <= in_mag;
         neg_a_ff <= in_neg;
         mag_b_ff <= mag_a_ff;
         neg_b_ff <= neg_a_ff;
         amt_ff   <= amt_in;
         left_ff  <= left_in;
         zero_ff  <= zero_in;
         vec_c_ff <= vec_c_in;
         sq_ff    <= sq_in;
         vec_d_ff <= vec_c_ff;
         sum_ff   <= sum_in;
         vec_e_ff <= vec_d_ff;
      end
   end

   assign out_valid = ve_ff;
   assign out_vec   = vec_e_ff;
   assign out_sum   = sum_ff;

endmodule

// ----- hw/rtl/pcrd_sqrt.sv -----
module pcrd_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  pcrd_pkg::vec_type           in_vec,
   input  logic [pcrd_pkg::SUM_W-1:0]  in_sum,
   output logic                        out_valid,
   output pcrd_pkg::vec_type           out_vec,
   output logic [pcrd_pkg::ROOT_W-1:0] out_root
);

   localparam int N  = pcrd_pkg::ROOT_W;
   localparam int RW = pcrd_pkg::REM_W;
   localparam int SW = pcrd_pkg::SUM_W;

   logic          valid_ff [N];
   logic [RW-1:0] rem_in [N], rem_ff [N];
   logic [N-1:0]  root_in [N], root_ff [N];
   logic [SW-1:0] s_in [N], s_ff [N];
   pcrd_pkg::vec_type vec_ff [N];

   // one root bit per stage, two radicand bits shifted in each time
   always_comb begin
      logic [RW-1:0] rem_p, rem2, trial;
      logic [N-1:0]  root_p;
      logic [SW-1:0] s_p;
      for (int k = 0; k < N; k++) begin
         rem_p  = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
         root_p = (k == 0) ? '0 : root_ff[(k == 0) ? 0 : k-1];
         s_p    = (k == 0) ? in_sum : s_ff[(k == 0) ? 0 : k-1];
         rem2   = {rem_p[RW-3:0], s_p[SW-1:SW-2]};
         trial  = {root_p, 2'b01};
         if (rem2 >= trial) begin
            rem_in[k]  = rem2 - trial;
            root_in[k] = {root_p[N-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem2;
            root_in[k] = {root_p[N-2:0], 1'b0};
         end
         s_in[k] = {s_p[SW-3:0], 2'b00};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < N; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         s_ff    <= s_in;
         vec_ff[0] <= in_vec;
         for (int k = 1; k < N; k++) vec_ff[k] <= vec_ff[k-1];
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_vec   = vec_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

// ----- hw/rtl/pcrd_div.sv -----
module pcrd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  pcrd_pkg::vec_type           in_vec,
   input  logic [pcrd_pkg::ROOT_W-1:0] in_root,
   output logic                        out_valid,
   output logic signed [15:0]          out_dir [3],
   output logic                        out_zero
);

   localparam int QW = pcrd_pkg::Q_W;
   localparam int NW = pcrd_pkg::NUM_W;
   localparam int DW = pcrd_pkg::DREM_W;
   localparam int LW = pcrd_pkg::ROOT_W;

   logic          vp_ff, vo_ff;
   logic [NW-1:0] num_in [3], num_ff [3];
   logic [LW-1:0] len_ff;
   pcrd_pkg::vec_type vec_p_ff;
   logic          valid_ff [QW];
   logic [DW-1:0] drem_in [QW][3], drem_ff [QW][3];
   logic [QW-1:0] lo_in [QW][3], lo_ff [QW][3];
   logic [QW-1:0] q_in [QW][3], q_ff [QW][3];
   logic [LW-1:0] lens_ff [QW];
   pcrd_pkg::vec_type vec_ff [QW];
   logic signed [15:0] dir_in [3], dir_ff [3];
   logic          zero_ff;

   // numerator with half the length added for rounding
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = NW'({in_vec.mag[i], pcrd_pkg::FRAC_W'(0)}) + NW'(in_root[LW-1:1]);
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [DW-1:0] rem_p, trial;
      logic [QW-1:0] lo_p, q_p;
      logic [LW-1:0] len_p;
      for (int k = 0; k < QW; k++) begin
         len_p = (k == 0) ? len_ff : lens_ff[(k == 0) ? 0 : k-1];
         for (int i = 0; i < 3; i++) begin
            rem_p = (k == 0) ? DW'(num_ff[i][NW-1:QW]) : drem_ff[(k == 0) ? 0 : k-1][i];
            lo_p  = (k == 0) ? num_ff[i][QW-1:0] : lo_ff[(k == 0) ? 0 : k-1][i];
            q_p   = (k == 0) ? '0 : q_ff[(k == 0) ? 0 : k-1][i];
            trial = {rem_p[DW-2:0], lo_p[QW-1]};
            if (trial >= DW'(len_p)) begin
               drem_in[k][i] = trial - DW'(len_p);
               q_in[k][i]    = {q_p[QW-2:0], 1'b1};
            end else begin
               drem_in[k][i] = trial;
               q_in[k][i]    = {q_p[QW-2:0], 1'b0};
            end
            lo_in[k][i] = {lo_p[QW-2:0], 1'b0};
         end
      end
   end

   // sign and zero vector handling
   always_comb begin
      logic [15:0] qe;
      for (int i = 0; i < 3; i++) begin
         qe = 16'(q_ff[QW-1][i]);
         if (vec_ff[QW-1].zero) dir_in[i] = '0;
         else if (vec_ff[QW-1].neg[i]) dir_in[i] = $signed(-qe);
         else dir_in[i] = $signed(qe);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int k = 0; k < QW; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         vp_ff <= in_valid;
         valid_ff[0] <= vp_ff;
         for (int k = 1; k < QW; k++) valid_ff[k] <= valid_ff[k-1];
         vo_ff <= valid_ff[QW-1];
      end
   end

   // data stages and output word
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         len_ff   <= in_root;
         vec_p_ff <= in_vec;
         drem_ff  <= drem_in;
         lo_ff    <= lo_in;
         q_ff     <= q_in;
         lens_ff[0] <= len_ff;
         vec_ff[0]  <= vec_p_ff;
         for (int k = 1; k < QW; k++) begin
            lens_ff[k] <= lens_ff[k-1];
            vec_ff[k]  <= vec_ff[k-1];
         end
         dir_ff  <= dir_in;
         zero_ff <= vec_ff[QW-1].zero;
      end
   end

   assign out_valid = vo_ff;
   assign out_dir   = dir_ff;
   assign out_zero  = zero_ff;

endmodule

// ----- hw/rtl/pinhole_camera_ray_direction.sv -----
// pinhole camera primary ray direction, one pixel word in, one unit direction out
// the path from req accept to rsp_valid runs through the 31-stage square root
// and the 15-stage divider, one result bit per stage
// throughput: one word per cycle; the whole pipe holds while a result waits
// reset: synchronous, clears all valid bits and loads the default camera registers
module pinhole_camera_ray_direction #(
   parameter int PIXEL_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_BITS-1:0] req_pixel_x,
   input  logic [PIXEL_BITS-1:0] req_pixel_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_dir_x,
   output logic signed [15:0]    rsp_dir_y,
   output logic signed [15:0]    rsp_dir_z,
   output logic                  rsp_zero_length,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [47:0]           csr_data
);

   localparam int AW = ((PIXEL_BITS > 12) ? PIXEL_BITS : 12) + 1;
   localparam int MW = AW + 22;

   logic [47:0] right_ff, up_ff, back_ff;
   logic [15:0] focal_ff;
   logic [12:0] width_ff, height_ff;
   logic        en;
   logic        vec_valid, norm_valid, sqrt_valid;
   logic [MW-1:0] vec_mag [3];
   logic [2:0]  vec_neg;
   pcrd_pkg::vec_type norm_vec, sqrt_vec;
   logic [pcrd_pkg::SUM_W-1:0]  norm_sum;
   logic [pcrd_pkg::ROOT_W-1:0] sqrt_root;
   logic signed [15:0] dir [3];

   // camera registers
   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff  <= 48'd16384;
         up_ff     <= 48'd1073741824;
         back_ff   <= 48'd70368744177664;
         focal_ff  <= 16'd14960;
         width_ff  <= 13'd1920;
         height_ff <= 13'd1080;
      end else if (csr_valid) begin
         case (csr_index)
            pcrd_pkg::CSR_AXIS_RIGHT:   right_ff  <= csr_data;
            pcrd_pkg::CSR_AXIS_UP:      up_ff     <= csr_data;
            pcrd_pkg::CSR_AXIS_BACK:    back_ff   <= csr_data;
            pcrd_pkg::CSR_FOCAL:        focal_ff  <= csr_data[15:0];
            pcrd_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data[12:0];
            pcrd_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // pipe advances when the output slot is free or being taken
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   pcrd_vec #(.PIXEL_BITS(PIXEL_BITS), .MW(MW)) u_vec (
      .clock, .reset, .en,
      .in_valid       (req_valid),
      .pixel_x        (req_pixel_x),
      .pixel_y        (req_pixel_y),
      .axis_right     (right_ff),
      .axis_up        (up_ff),
      .axis_back      (back_ff),
      .focal_distance (focal_ff),
      .frame_width    (width_ff),
      .frame_height   (height_ff),
      .out_valid      (vec_valid),
      .out_mag        (vec_mag),
      .out_neg        (vec_neg)
   );

   pcrd_norm #(.MW(MW)) u_norm (
      .clock, .reset, .en,
      .in_valid  (vec_valid),
      .in_mag    (vec_mag),
      .in_neg    (vec_neg),
      .out_valid (norm_valid),
      .out_vec   (norm_vec),
      .out_sum   (norm_sum)
   );

   pcrd_sqrt u_sqrt (
      .clock, .reset, .en,
      .in_valid  (norm_valid),
      .in_vec    (norm_vec),
      .in_sum    (norm_sum),
      .out_valid (sqrt_valid),
      .out_vec   (sqrt_vec),
      .out_root  (sqrt_root)
   );

   pcrd_div u_div (
      .clock, .reset, .en,
      .in_valid  (sqrt_valid),
      .in_vec    (sqrt_vec),
      .in_root   (sqrt_root),
      .out_valid (rsp_valid),
      .out_dir   (dir),
      .out_zero  (rsp_zero_length)
   );

   assign rsp_dir_x = dir[0];
   assign rsp_dir_y = dir[1];
   assign rsp_dir_z = dir[2];

endmodule

// ----- hw/rtl/pcrd_checker.sv -----
`include "pinhole_camera_ray_direction_defines.svh"

module pcrd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_dir_x,
   input logic signed [15:0] rsp_dir_y,
   input logic signed [15:0] rsp_dir_z,
   input logic               rsp_zero_length
);

   logic        dir_zero, dir_in_unit, rsp_stall;
   logic [48:0] rsp_word;

   // helper terms for the checks below
   assign dir_zero    = rsp_dir_x == 16'sd0 && rsp_dir_y == 16'sd0 && rsp_dir_z == 16'sd0;
   assign dir_in_unit = rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384
                     && rsp_dir_y <= 16'sd16384 && rsp_dir_y >= -16'sd16384
                     && rsp_dir_z <= 16'sd16384 && rsp_dir_z >= -16'sd16384;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_zero_length, rsp_dir_z, rsp_dir_y, rsp_dir_x};

   // a zero vector word carries zero components
   `PCRD_ASSERT(a_zero_dir, rsp_valid && rsp_zero_length |-> dir_zero, "zero word with direction")

   // unit components never exceed one
   `PCRD_ASSERT(a_unit_range, rsp_valid |-> dir_in_unit, "direction component out of range")

   // a held result blocks new words
   `PCRD_ASSERT(a_stall_blocks, rsp_stall |-> !req_ready, "input open while stalled")

   // a stalled result holds
   `PCRD_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled result changed")

   // nothing comes out right after reset
   `PCRD_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind pinhole_camera_ray_direction pcrd_checker u_pcrd_checker (.*);

// ----- test/tb_pinhole_camera_ray_direction.sv -----
`timescale 1ns / 100ps

module tb_pinhole_camera_ray_direction;

   localparam int PIX_W = 12;
   localparam int STALL_LIMIT = 20000;
   localparam int LATENCY = 57;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [PIX_W-1:0]  req_pixel_x = '0;
   logic [PIX_W-1:0]  req_pixel_y = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic              rsp_zero_length;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [47:0]       csr_data = '0;

   typedef struct packed {
      logic [15:0] dx;
      logic [15:0] dy;
      logic [15:0] dz;
      logic        zl;
   } ray_dir_type;

   // camera registers as the predictor sees them
   logic [47:0] cam_right, cam_up, cam_back;
   logic [15:0] cam_focal;
   logic [12:0] cam_width, cam_height;

   ray_dir_type dir_queue[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit stall_free = 0;

   pinhole_camera_ray_direction #(.PIXEL_BITS(PIX_W)) dut (.*);

   always #6 clock = ~clock;

   // signed Q1.14 component of a packed axis
   function automatic longint axis_comp(logic [47:0] axis, int idx);
      logic signed [15:0] c;
      c = axis[16*idx +: 16];
      return longint'(c);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s = s - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // unit ray direction through one pixel
   function automatic ray_dir_type ray_direction(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      ray_dir_type r;
      longint a, b, f, v;
      longint unsigned mag[3];
      bit neg[3];
      longint unsigned m, s, len, q;
      logic [15:0] o[3];
      a = longint'(px) - longint'(cam_width >> 1);
      b = longint'(cam_height >> 1) - longint'(py);
      f = longint'(cam_focal);
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         v = 16 * (a * axis_comp(cam_right, i) + b * axis_comp(cam_up, i))
             - f * axis_comp(cam_back, i);
         neg[i] = v < 0;
         mag[i] = neg[i] ? longint'(-v) : v;
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         r.dx = '0; r.dy = '0; r.dz = '0; r.zl = 1'b1;
         return r;
      end
      while (m >= (64'd1 << 30)) begin
         m = m >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
         m = m << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << 14) + (len >> 1)) / len;
         o[i] = neg[i] ? 16'(17'h10000 - q) : 16'(q);
      end
      r.dx = o[0]; r.dy = o[1]; r.dz = o[2]; r.zl = 1'b0;
      return r;
   endfunction

   // send one pixel word, predicting at acceptance
   task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      req_valid = 1'b1;
      req_pixel_x = px;
      req_pixel_y = py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      dir_queue.push_back(ray_direction(px, py));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // burst sender: random gap before some words
   task automatic send_burst_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 6)) @(negedge clock);
      send_pixel(px, py);
   endtask

   task automatic drain();
      while (dir_queue.size() != 0 && !timed_out) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [47:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         pcrd_pkg::CSR_AXIS_RIGHT:   cam_right = data;
         pcrd_pkg::CSR_AXIS_UP:      cam_up = data;
         pcrd_pkg::CSR_AXIS_BACK:    cam_back = data;
         pcrd_pkg::CSR_FOCAL:        cam_focal = data[15:0];
         pcrd_pkg::CSR_FRAME_WIDTH:  cam_width = data[12:0];
         pcrd_pkg::CSR_FRAME_HEIGHT: cam_height = data[12:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [47:0] pack_axis(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      return {z, y, x};
   endfunction

   // directed: default camera, field extremes, zero vectors, extreme axes and frames
   task automatic test_directed();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd960, 12'd540);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'haaa, 12'h555);
      send_pixel(12'h555, 12'haaa);
      drain();
      // zero focal and center pixel gives a zero vector
      write_reg(pcrd_pkg::CSR_FOCAL, 48'd0);
      send_pixel(12'd960, 12'd540);
      send_pixel(12'd961, 12'd540);
      drain();
      // extreme axes and frames, unused indexes ignored
      write_reg(pcrd_pkg::CSR_AXIS_RIGHT, pack_axis(16'h8000, 16'h7fff, 16'h8000));
      write_reg(pcrd_pkg::CSR_AXIS_UP, pack_axis(16'h7fff, 16'h8000, 16'h7fff));
      write_reg(pcrd_pkg::CSR_AXIS_BACK, pack_axis(16'h8000, 16'h8000, 16'h7fff));
      write_reg(pcrd_pkg::CSR_FOCAL, 48'hffff);
      write_reg(pcrd_pkg::CSR_FRAME_WIDTH, 48'h1fff);
      write_reg(pcrd_pkg::CSR_FRAME_HEIGHT, 48'd0);
      write_reg(3'd6, 48'hffffffffffff);
      write_reg(3'd7, 48'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      drain();
      write_reg(pcrd_pkg::CSR_FRAME_WIDTH, 48'd1);
      write_reg(pcrd_pkg::CSR_FRAME_HEIGHT, 48'd4096);
      write_reg(pcrd_pkg::CSR_AXIS_BACK, 48'd0);
      write_reg(pcrd_pkg::CSR_AXIS_UP, 48'd0);
      write_reg(pcrd_pkg::CSR_AXIS_RIGHT, 48'd0);
      send_pixel(12'd7, 12'd9);
      send_pixel(12'd0, 12'd2048);
      drain();
   endtask

   // random camera settings, then random pixels
   task automatic test_random_cameras(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_reg(pcrd_pkg::CSR_AXIS_RIGHT, 48'({$urandom, $urandom}));
         write_reg(pcrd_pkg::CSR_AXIS_UP, 48'({$urandom, $urandom}));
         write_reg(pcrd_pkg::CSR_AXIS_BACK, 48'({$urandom, $urandom}));
         write_reg(pcrd_pkg::CSR_FOCAL, 48'($urandom_range(0, 65535)));
         write_reg(pcrd_pkg::CSR_FRAME_WIDTH, 48'($urandom_range(0, 8191)));
         write_reg(pcrd_pkg::CSR_FRAME_HEIGHT, 48'($urandom_range(0, 8191)));
         stall_free = (p % 3 == 0);
         for (int i = 0; i < per_phase; i++)
            send_burst_pixel(PIX_W'($urandom), PIX_W'($urandom));
         // in the second phase, hold off until every result is back, then continue
         if (p == 1) while (dir_queue.size() != 0) @(negedge clock);
         drain();
      end
      stall_free = 0;
   endtask

   // realistic cameras: unit axes, raster-like walk
   task automatic test_raster_walk(int count);
      logic [PIX_W-1:0] x0, y0;
      write_reg(pcrd_pkg::CSR_AXIS_RIGHT, pack_axis(16'h4000, 16'h0000, 16'h0000));
      write_reg(pcrd_pkg::CSR_AXIS_UP, pack_axis(16'h0000, 16'h4000, 16'h0000));
      write_reg(pcrd_pkg::CSR_AXIS_BACK, pack_axis(16'h0000, 16'h0000, 16'h4000));
      write_reg(pcrd_pkg::CSR_FOCAL, 48'd8000);
      write_reg(pcrd_pkg::CSR_FRAME_WIDTH, 48'd640);
      write_reg(pcrd_pkg::CSR_FRAME_HEIGHT, 48'd480);
      x0 = PIX_W'($urandom_range(0, 600));
      y0 = PIX_W'($urandom_range(0, 470));
      for (int i = 0; i < count; i++)
         send_burst_pixel(x0 + PIX_W'(i % 40), y0 + PIX_W'(i / 40));
      drain();
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (stall_free) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // result check
   always @(posedge clock) begin
      ray_dir_type exp_dir;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dir_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word");
         end else begin
            exp_dir = dir_queue.pop_front();
            if (rsp_dir_x !== exp_dir.dx || rsp_dir_y !== exp_dir.dy ||
                rsp_dir_z !== exp_dir.dz || rsp_zero_length !== exp_dir.zl) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                           exp_dir.dx, exp_dir.dy, exp_dir.dz, exp_dir.zl,
                           rsp_dir_x, rsp_dir_y, rsp_dir_z, rsp_zero_length);
            end
         end
      end
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      cam_right = 48'd16384;
      cam_up = 48'd1073741824;
      cam_back = 48'd70368744177664;
      cam_focal = 16'd14960;
      cam_width = 13'd1920;
      cam_height = 13'd1080;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_cameras(6, 40);
      test_raster_walk(160);
      if (mismatches == 0 && dir_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pcrd_pkg.sv
hw/rtl/pcrd_vec.sv
hw/rtl/pcrd_norm.sv
hw/rtl/pcrd_sqrt.sv
hw/rtl/pcrd_div.sv
hw/rtl/pinhole_camera_ray_direction.sv
hw/rtl/pcrd_checker.sv
test/tb_pinhole_camera_ray_direction.sv
